>>> sv/iiee_pkg.sv
// ----------------------------------------------------------------------------
// iiee_pkg: shared definitions for the infix integer expression evaluator
// Holds the value width, character codes, operator codes, state encodings
// and the request and response bundles of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package iiee_pkg;

  localparam int VW    = 32;
  localparam int CNT_W = $clog2(VW);

  localparam logic [7:0] CH_EQ  = 8'h3D;  // '='
  localparam logic [7:0] CH_MUL = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV = 8'h2F;  // '/'
  localparam logic [7:0] CH_ADD = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB = 8'h2D;  // '-'
  localparam logic [7:0] CH_SP  = 8'h20;  // ' ', ignored like any other byte
  localparam logic [7:0] CH_0   = 8'h30;  // '0'
  localparam logic [7:0] CH_9   = 8'h39;  // '9'
  localparam int         RADIX  = 10;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } md_req_t;

  typedef struct packed {
    logic          done;
    logic          dz;
    logic [VW-1:0] result;
  } md_rsp_t;

endpackage

>>> sv/iiee_muldiv.sv
// ----------------------------------------------------------------------------
// iiee_muldiv: iterative multiply and signed divide unit
// Shift-add multiply and restoring divide, one bit per cycle, sharing one
// set of working registers.
// ----------------------------------------------------------------------------
module iiee_muldiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iiee_pkg::md_req_t        req,
  input  logic [iiee_pkg::VW-1:0]  a,
  input  logic [iiee_pkg::VW-1:0]  b,
  output iiee_pkg::md_rsp_t        rsp
);

  localparam int VW = iiee_pkg::VW;

  iiee_pkg::md_state_t state_r, state_nxt;
  iiee_pkg::op_t       op_r, op_nxt;
  logic [VW-1:0]       rem_r, rem_nxt;   // remainder, or product accumulator
  logic [VW-1:0]       quo_r, quo_nxt;   // quotient, or multiplier
  logic [VW-1:0]       div_r, div_nxt;   // divisor magnitude, or multiplicand
  logic                neg_r, neg_nxt;
  logic                dz_r, dz_nxt;
  logic [iiee_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic          sa, sb;
  logic [VW-1:0] ma, mb;
  logic [VW:0]   trial;

  assign sa    = a[VW-1];
  assign sb    = b[VW-1];
  assign ma    = sa ? (VW'(0) - a) : a;
  assign mb    = sb ? (VW'(0) - b) : b;
  assign trial = {rem_r, quo_r[VW-1]} - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iiee_pkg::MD_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r  <= op_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    dz_r  <= dz_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    neg_nxt   = neg_r;
    dz_nxt    = dz_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      iiee_pkg::MD_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          cnt_nxt = iiee_pkg::CNT_W'(VW - 1);
          dz_nxt  = 1'b0;
          neg_nxt = 1'b0;
          rem_nxt = '0;
          if (req.op == iiee_pkg::OP_DIV) begin
            if (b == '0) begin
              quo_nxt   = '0;
              dz_nxt    = 1'b1;
              state_nxt = iiee_pkg::MD_DONE;
            end else begin
              quo_nxt   = ma;
              div_nxt   = mb;
              neg_nxt   = sa ^ sb;
              state_nxt = iiee_pkg::MD_DIV;
            end
          end else begin
            quo_nxt   = b;
            div_nxt   = a;
            state_nxt = iiee_pkg::MD_MUL;
          end
        end
      end
      iiee_pkg::MD_MUL: begin
        if (quo_r[0]) begin
          rem_nxt = rem_r + div_r;
        end
        div_nxt = {div_r[VW-2:0], 1'b0};
        quo_nxt = {1'b0, quo_r[VW-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = iiee_pkg::MD_DONE;
        end
      end
      iiee_pkg::MD_DIV: begin
        if (!trial[VW]) begin
          rem_nxt = trial[VW-1:0];
        end else begin
          rem_nxt = {rem_r[VW-2:0], quo_r[VW-1]};
        end
        quo_nxt = {quo_r[VW-2:0], ~trial[VW]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = iiee_pkg::MD_DONE;
        end
      end
      iiee_pkg::MD_DONE: begin
        state_nxt = iiee_pkg::MD_IDLE;
      end
      default: begin
        state_nxt = iiee_pkg::MD_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.done = (state_r == iiee_pkg::MD_DONE);
    rsp.dz   = dz_r;
    if (op_r == iiee_pkg::OP_DIV) begin
      rsp.result = neg_r ? (VW'(0) - quo_r) : quo_r;
    end else begin
      rsp.result = rem_r;
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done)
    else $error("muldiv done held for more than one cycle");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp.done && rsp.dz) |-> (rsp.result == '0))
    else $error("division by zero did not give a zero quotient");
`endif

endmodule

>>> sv/infix_integer_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator_unit: character-stream expression evaluator
// Reads one byte per transfer and evaluates an infix integer expression with
// + - * / and the usual precedence, emitting the value on '='.
// ----------------------------------------------------------------------------
// Each input transfer carries one byte. Digits build an unsigned decimal number,
// '*' and '/' fold it into the current term (left to right, division truncating
// toward zero), '+' and '-' fold the term into the running sum, and '=' finishes
// the expression, produces one output transfer carrying the 32-bit two's
// complement value and a flag that is set if any division by zero occurred,
// and returns the evaluator to its cleared state. All other bytes are ignored.
// Arithmetic wraps at 32 bits; a division by zero yields 0 and sets the flag.
// Sequencing: a digit, an ignored byte, or an operator that closes a plain
// number is taken while the evaluator stays idle. An operator that completes a
// pending multiply or divide waits on the shared bit-serial multiply/divide
// unit (start, bit iterations, done); a division by zero skips the iterations.
// An '=' adds a state that loads the output register and waits there while a
// previous result is pending. The input side stalls while an item is in work.
module infix_integer_expression_evaluator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_character,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [iiee_pkg::VW-1:0] out_value,
  output logic                           out_div_by_zero
);

  localparam int VW = iiee_pkg::VW;

  iiee_pkg::state_t state_r, state_nxt;
  iiee_pkg::op_t    pend_op_r, pend_op_nxt;
  logic [VW-1:0]    sum_r, sum_nxt;
  logic [VW-1:0]    term_r, term_nxt;
  logic [VW-1:0]    num_r, num_nxt;
  logic             sub_r, sub_nxt;
  logic             zdiv_r, zdiv_nxt;
  logic [7:0]       act_r, act_nxt;      // operator byte waiting on the unit
  logic             out_valid_r, out_valid_nxt;
  logic [VW-1:0]    out_value_r, out_value_nxt;
  logic             out_dz_r, out_dz_nxt;

  iiee_pkg::md_req_t md_req;
  iiee_pkg::md_rsp_t md_rsp;

  logic          acc;
  logic          is_digit;
  logic          is_op;
  logic [7:0]    digit;
  logic          fold;
  logic [VW-1:0] ft;        // value of the term once the pending number is folded
  logic [7:0]    fch;       // operator that applies to the folded term
  logic [VW-1:0] sum_fold;

  iiee_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a     (term_r),
    .b     (num_r),
    .rsp   (md_rsp)
  );

  assign in_stall        = (state_r != iiee_pkg::ST_IDLE);
  assign acc             = in_valid && !in_stall;
  assign digit           = in_character - iiee_pkg::CH_0;
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_div_by_zero = out_dz_r;

  always_comb begin
    is_digit = in_character inside {[iiee_pkg::CH_0:iiee_pkg::CH_9]};
    is_op    = in_character inside {iiee_pkg::CH_MUL, iiee_pkg::CH_DIV,
                                    iiee_pkg::CH_ADD, iiee_pkg::CH_SUB,
                                    iiee_pkg::CH_EQ};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iiee_pkg::ST_IDLE;
      pend_op_r   <= iiee_pkg::OP_NONE;
      sum_r       <= '0;
      term_r      <= '0;
      num_r       <= '0;
      sub_r       <= 1'b0;
      zdiv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_op_r   <= pend_op_nxt;
      sum_r       <= sum_nxt;
      term_r      <= term_nxt;
      num_r       <= num_nxt;
      sub_r       <= sub_nxt;
      zdiv_r      <= zdiv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r       <= act_nxt;
    out_value_r <= out_value_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pend_op_nxt   = pend_op_r;
    sum_nxt       = sum_r;
    term_nxt      = term_r;
    num_nxt       = num_r;
    sub_nxt       = sub_r;
    zdiv_nxt      = zdiv_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_dz_nxt    = out_dz_r;
    md_req.start  = 1'b0;
    md_req.op     = pend_op_r;
    fold          = 1'b0;
    ft            = num_r;
    fch           = in_character;

    case (state_r)
      iiee_pkg::ST_IDLE: begin
        if (acc && is_digit) begin
          // number * 10 + digit, as two shifts and adds
          num_nxt = {num_r[VW-4:0], 3'b000} + {num_r[VW-2:0], 1'b0} + VW'(digit);
        end else if (acc && is_op) begin
          if (pend_op_r == iiee_pkg::OP_MUL || pend_op_r == iiee_pkg::OP_DIV) begin
            md_req.start = 1'b1;
            act_nxt      = in_character;
            state_nxt    = iiee_pkg::ST_WAIT;
          end else begin
            fold = 1'b1;
          end
        end
      end
      iiee_pkg::ST_WAIT: begin
        if (md_rsp.done) begin
          fold     = 1'b1;
          ft       = md_rsp.result;
          fch      = act_r;
          zdiv_nxt = zdiv_r | md_rsp.dz;
        end
      end
      iiee_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = sum_r;
          out_dz_nxt    = zdiv_r;
          sum_nxt       = '0;
          term_nxt      = '0;
          num_nxt       = '0;
          sub_nxt       = 1'b0;
          zdiv_nxt      = 1'b0;
          pend_op_nxt   = iiee_pkg::OP_NONE;
          state_nxt     = iiee_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = iiee_pkg::ST_IDLE;
      end
    endcase

    // The folded term is either kept for a following * or /, or merged into
    // the sum with the sign chosen by the previous additive operator.
    sum_fold = sub_r ? (sum_r - ft) : (sum_r + ft);
    if (fold) begin
      num_nxt     = '0;
      pend_op_nxt = iiee_pkg::OP_NONE;
      term_nxt    = ft;
      state_nxt   = iiee_pkg::ST_IDLE;
      case (fch)
        iiee_pkg::CH_MUL: begin
          pend_op_nxt = iiee_pkg::OP_MUL;
        end
        iiee_pkg::CH_DIV: begin
          pend_op_nxt = iiee_pkg::OP_DIV;
        end
        iiee_pkg::CH_ADD, iiee_pkg::CH_SUB: begin
          sum_nxt  = sum_fold;
          term_nxt = '0;
          sub_nxt  = (fch == iiee_pkg::CH_SUB);
        end
        iiee_pkg::CH_EQ: begin
          sum_nxt   = sum_fold;
          term_nxt  = '0;
          state_nxt = iiee_pkg::ST_EMIT;
        end
        default: begin
          term_nxt = ft;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == iiee_pkg::ST_EMIT))
    else $error("result presented without a finished expression");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iiee_pkg::ST_EMIT && (!out_valid_r || !out_stall)) |=>
      (sum_r == '0 && num_r == '0 && term_r == '0 && !zdiv_r &&
       state_r == iiee_pkg::ST_IDLE))
    else $error("evaluator state not cleared after a result");

  a_start_pending: assert property (@(posedge clk) disable iff (!rst_n)
    md_req.start |-> (state_r == iiee_pkg::ST_IDLE &&
                      (pend_op_r == iiee_pkg::OP_MUL || pend_op_r == iiee_pkg::OP_DIV)))
    else $error("muldiv started without a pending multiply or divide");
`endif

endmodule
